// ----- src/tcse_pkg.sv -----
// Shared types and constants for the text console screen engine.
// Depends on nothing; every other file of the block imports it.
package tcse_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int NCELLS = COLS * ROWS;

    // Field widths of the transaction and result payloads
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int IDX_W  = 11;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = ATTR_W + CHAR_W;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BS      = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL      = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } tcse_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } tcse_item_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              scrolled;
        logic [CELL_W-1:0] cell_value;
    } tcse_result_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NOP        = 4'd0,
        OP_LATCH      = 4'd1,
        OP_PUT        = 4'd2,
        OP_READ       = 4'd3,
        OP_CAPTURE    = 4'd4,
        OP_FILL       = 4'd5,
        OP_FILL_RESET = 4'd6,
        OP_COPY       = 4'd7,
        OP_BLANK      = 4'd8
    } tcse_op_t;

    typedef struct packed {
        tcse_op_t op;
    } tcse_dp_cmd_t;

    typedef struct packed {
        logic scroll_req;
        logic sweep_end;
    } tcse_dp_stat_t;

endpackage

// ----- src/tcse_ctrl.sv -----
// Controller state machine of the text console screen engine.
// Depends on tcse_pkg; drives the datapath operation and the handshake.
module tcse_ctrl
    import tcse_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [CMD_W-1:0] command,
    input  tcse_dp_stat_t   stat,
    output tcse_dp_cmd_t    cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [8:0] {
        ST_INIT   = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_PUT    = 9'b000000100,
        ST_READ   = 9'b000001000,
        ST_RDCAP  = 9'b000010000,
        ST_FILL   = 9'b000100000,
        ST_COPY   = 9'b001000000,
        ST_BLANK  = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        case (state_reg)
            ST_INIT:
            begin
                cmd.op = OP_FILL_RESET;
                if (stat.sweep_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LATCH;
                    case (command)
                        CMD_PUT:   state_next = ST_PUT;
                        CMD_CLEAR: state_next = ST_FILL;
                        CMD_READ:  state_next = ST_READ;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_PUT:
            begin
                cmd.op     = OP_PUT;
                state_next = stat.scroll_req ? ST_COPY : ST_DONE;
            end
            ST_READ:
            begin
                cmd.op     = OP_READ;
                state_next = ST_RDCAP;
            end
            ST_RDCAP:
            begin
                cmd.op     = OP_CAPTURE;
                state_next = ST_DONE;
            end
            ST_FILL:
            begin
                cmd.op = OP_FILL;
                if (stat.sweep_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_COPY:
            begin
                cmd.op = OP_COPY;
                if (stat.sweep_end)
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                cmd.op = OP_BLANK;
                if (stat.sweep_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

// ----- src/tcse_datapath.sv -----
// Datapath of the text console screen engine: screen memory, cursor,
// sweep counter and result registers. Depends on tcse_pkg.
module tcse_datapath
    import tcse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tcse_dp_cmd_t      cmd,
    input  tcse_item_t        item,
    input  logic              cfg_we,
    input  logic [ATTR_W-1:0] cfg_data,
    output tcse_dp_stat_t     stat,
    output tcse_result_t      result
);

    localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(NCELLS - 1);
    localparam logic [IDX_W-1:0] LAST_COPY = IDX_W'((ROWS - 1) * COLS - 1);
    localparam logic [IDX_W-1:0] ROW_STEP  = IDX_W'(COLS);

    logic [CELL_W-1:0] mem [NCELLS];

    tcse_item_t        item_reg;
    logic [ATTR_W-1:0] attr_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  line_reg;
    logic              scrolled_reg;
    logic [CELL_W-1:0] cell_reg;
    logic [IDX_W-1:0]  addr_reg;
    logic [IDX_W-1:0]  addr_next;
    logic              pend_reg;
    logic [IDX_W-1:0]  wr_addr_reg;
    logic [CELL_W-1:0] rd_data_reg;

    logic [COL_W:0]    put_col;
    logic [ROW_W:0]    put_line;
    logic [COL_W-1:0]  put_col_addr;
    logic [CHAR_W-1:0] put_chr;
    logic              put_we;
    logic              scroll_req;
    logic              sweep_end;
    logic [ROW_W-1:0]  final_line;
    logic [IDX_W-1:0]  put_addr;
    logic              idx_ok;

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [CELL_W-1:0] wdata;
    logic              rd_en;
    logic [IDX_W-1:0]  raddr;

    // Cursor movement for a put transaction
    always_comb
    begin
        put_col      = {1'b0, col_reg};
        put_line     = {1'b0, line_reg};
        put_col_addr = col_reg;
        put_chr      = item_reg.char_code;
        put_we       = 1'b0;
        case (item_reg.char_code)
            CH_NL:
            begin
                put_col  = '0;
                put_line = put_line + 1'b1;
            end
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    put_col      = put_col - 1'b1;
                    put_col_addr = col_reg - 1'b1;
                    put_chr      = CH_SPACE;
                    put_we       = 1'b1;
                end
            end
            CH_TAB:
            begin
                put_col = (put_col + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
            end
            default:
            begin
                put_we  = 1'b1;
                put_col = put_col + 1'b1;
            end
        endcase
        if (put_col >= (COL_W+1)'(COLS))
        begin
            put_col  = '0;
            put_line = put_line + 1'b1;
        end
        scroll_req = (put_line >= (ROW_W+1)'(ROWS));
        final_line = scroll_req ? ROW_W'(ROWS - 1) : put_line[ROW_W-1:0];
        put_addr   = IDX_W'(IDX_W'(line_reg) * ROW_STEP) + IDX_W'(put_col_addr);
    end

    assign idx_ok = (item_reg.cell_index < IDX_W'(NCELLS));

    // Single write port: a pending copy write takes priority
    always_comb
    begin
        we    = 1'b0;
        waddr = addr_reg;
        wdata = {attr_reg, CH_SPACE};
        if (pend_reg)
        begin
            we    = 1'b1;
            waddr = wr_addr_reg;
            wdata = rd_data_reg;
        end
        else
        begin
            case (cmd.op)
                OP_PUT:
                begin
                    we    = put_we;
                    waddr = put_addr;
                    wdata = {attr_reg, put_chr};
                end
                OP_FILL, OP_BLANK:
                begin
                    we = 1'b1;
                end
                OP_FILL_RESET:
                begin
                    we    = 1'b1;
                    wdata = {RESET_ATTR, CH_SPACE};
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    assign rd_en = (cmd.op == OP_COPY) || (cmd.op == OP_READ);
    assign raddr = (cmd.op == OP_COPY) ? (addr_reg + ROW_STEP)
                 : (idx_ok ? item_reg.cell_index : '0);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // Sweep counter and end-of-sweep detection
    always_comb
    begin
        addr_next = addr_reg;
        sweep_end = 1'b0;
        case (cmd.op)
            OP_LATCH:
            begin
                addr_next = '0;
            end
            OP_FILL, OP_FILL_RESET:
            begin
                addr_next = addr_reg + 1'b1;
                sweep_end = (addr_reg == LAST_CELL);
            end
            OP_COPY:
            begin
                addr_next = addr_reg + 1'b1;
                sweep_end = (addr_reg == LAST_COPY);
            end
            OP_BLANK:
            begin
                // hold while the last copy write drains
                if (!pend_reg)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                sweep_end = (addr_reg == LAST_CELL) && !pend_reg;
            end
            default:
            begin
                addr_next = addr_reg;
            end
        endcase
    end

    assign stat = '{scroll_req: scroll_req, sweep_end: sweep_end};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            pend_reg     <= 1'b0;
            attr_reg     <= RESET_ATTR;
            col_reg      <= '0;
            line_reg     <= '0;
            scrolled_reg <= 1'b0;
            cell_reg     <= '0;
        end
        else
        begin
            addr_reg <= addr_next;
            pend_reg <= (cmd.op == OP_COPY);
            if (cfg_we)
            begin
                attr_reg <= cfg_data;
            end
            case (cmd.op)
                OP_LATCH:
                begin
                    scrolled_reg <= 1'b0;
                    cell_reg     <= '0;
                end
                OP_PUT:
                begin
                    col_reg      <= put_col[COL_W-1:0];
                    line_reg     <= final_line;
                    scrolled_reg <= scroll_req;
                end
                OP_FILL:
                begin
                    col_reg  <= '0;
                    line_reg <= '0;
                end
                OP_CAPTURE:
                begin
                    cell_reg <= idx_ok ? rd_data_reg : '0;
                end
                default:
                begin
                    cell_reg <= cell_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= addr_reg;
        if (cmd.op == OP_LATCH)
        begin
            item_reg <= item;
        end
    end

    assign result.cursor_col = col_reg;
    assign result.cursor_row = line_reg;
    assign result.scrolled   = scrolled_reg;
    assign result.cell_value = cell_reg;

endmodule

// ----- src/text_console_screen_engine.sv -----
// Text console screen engine: 80x25 cell screen with cursor, put/clear/read.
// A put that scrolls then copies 24 rows up a cell a cycle, drains the last copy
// write and blanks the bottom row. A new transaction is taken only once the one
// before it is done; the receiver cannot stall. After reset busy stays high while
// the screen is filled with blanks of the reset attribute.
module text_console_screen_engine
    import tcse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tcse_item_t        item,
    output logic              done,
    output tcse_result_t      result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ATTR_W-1:0] cfg_data
);

    tcse_dp_cmd_t  dp_cmd;
    tcse_dp_stat_t dp_stat;

    assign cfg_ready = 1'b1;

    tcse_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (item.command),
        .stat    (dp_stat),
        .cmd     (dp_cmd),
        .busy    (busy),
        .done    (done)
    );

    tcse_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dp_cmd),
        .item     (item),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .stat     (dp_stat),
        .result   (result)
    );

endmodule

// ----- src/tcse_checker.sv -----
// Port-level checks for the text console screen engine.
// Depends on tcse_pkg; bound to text_console_screen_engine below.
module tcse_checker
    import tcse_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input logic         done,
    input tcse_result_t result
);

    // an accepted transaction makes the engine busy once its state is registered
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after accepting a transaction");

    // a result strobe lasts one cycle and comes while busy
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (busy ##1 !done))
        else $error("result strobe longer than one cycle or while idle");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.cursor_col < COL_W'(COLS)) && (result.cursor_row < ROW_W'(ROWS)))
        else $error("cursor out of screen");

    // a scroll always leaves the cursor on the bottom row
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.scrolled) |-> (result.cursor_row == ROW_W'(ROWS - 1)))
        else $error("scroll without cursor on bottom row");

    // a scrolling put never reports a cell
    a_scroll_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.scrolled) |-> (result.cell_value == '0))
        else $error("cell value reported on a scrolling transaction");

endmodule

bind text_console_screen_engine tcse_checker u_tcse_checker (.*);

// ----- tb/text_console_screen_engine_test.sv -----
// Self-checking testbench for text_console_screen_engine: directed and random command streams.
// Depends on tcse_pkg and the engine RTL only. A tracking class mirrors the screen and the cursor,
// and every result strobe is checked against it.
`timescale 1ns / 1ps

module text_console_screen_engine_test
    import tcse_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 95;
    localparam int DRAIN_CYCLES   = 2100;

    // Mirror of the screen, the cursor and the attribute register
    class console_screen_tracker;
        logic [CELL_W-1:0] cells [NCELLS];
        int unsigned       cursor_col;
        int unsigned       cursor_row;
        logic [ATTR_W-1:0] attribute;
        tcse_result_t      pending_results [$];
        int                mismatches;

        function new();
            attribute  = RESET_ATTR;
            cursor_col = 0;
            cursor_row = 0;
            mismatches = 0;
            fill_blank();
        endfunction

        function void fill_blank();
            foreach (cells[i])
                cells[i] = {attribute, CH_SPACE};
        endfunction

        function int unsigned cursor_cell();
            int unsigned p;
            p = cursor_row * COLS + cursor_col;
            return (p < NCELLS) ? p : 0;
        endfunction

        // Apply one character to the screen; return 1 if the screen scrolled
        function bit put_char(logic [CHAR_W-1:0] ch);
            if (ch == CH_NL)
            begin
                cursor_col = 0;
                cursor_row++;
            end
            else if (ch == CH_BS)
            begin
                if (cursor_col > 0)
                begin
                    cursor_col--;
                    cells[cursor_cell()] = {attribute, CH_SPACE};
                end
            end
            else if (ch == CH_TAB)
            begin
                cursor_col = (cursor_col + 4) & ~32'd3;
            end
            else
            begin
                cells[cursor_cell()] = {attribute, ch};
                cursor_col++;
            end
            if (cursor_col >= COLS)
            begin
                cursor_col = 0;
                cursor_row++;
            end
            if (cursor_row < ROWS)
                return 1'b0;
            for (int i = 0; i < (ROWS - 1) * COLS; i++)
                cells[i] = cells[i + COLS];
            for (int i = (ROWS - 1) * COLS; i < NCELLS; i++)
                cells[i] = {attribute, CH_SPACE};
            cursor_row = ROWS - 1;
            return 1'b1;
        endfunction

        function void note_command(tcse_item_t it);
            tcse_result_t want;
            want = '0;
            case (it.command)
                CMD_PUT:   want.scrolled = put_char(it.char_code);
                CMD_CLEAR:
                begin
                    fill_blank();
                    cursor_col = 0;
                    cursor_row = 0;
                end
                CMD_READ:
                begin
                    if (it.cell_index < NCELLS)
                        want.cell_value = cells[it.cell_index];
                end
                default: ;
            endcase
            want.cursor_col = cursor_col[COL_W-1:0];
            want.cursor_row = cursor_row[ROW_W-1:0];
            pending_results.push_back(want);
        endfunction

        function void check_result(tcse_result_t got);
            tcse_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.cursor_col !== want.cursor_col)
            begin
                $display("%0t: cursor_col expected %0d actual %0d",
                         $time, want.cursor_col, got.cursor_col);
                mismatches++;
            end
            if (got.cursor_row !== want.cursor_row)
            begin
                $display("%0t: cursor_row expected %0d actual %0d",
                         $time, want.cursor_row, got.cursor_row);
                mismatches++;
            end
            if (got.scrolled !== want.scrolled)
            begin
                $display("%0t: scrolled expected %0b actual %0b",
                         $time, want.scrolled, got.scrolled);
                mismatches++;
            end
            if (got.cell_value !== want.cell_value)
            begin
                $display("%0t: cell_value expected %h actual %h",
                         $time, want.cell_value, got.cell_value);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    tcse_item_t        item;
    logic              done;
    tcse_result_t      result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [ATTR_W-1:0] cfg_data;

    console_screen_tracker screen = new();
    int                    quiet_cycles;
    bit                    steady;

    text_console_screen_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Track accepted transactions, check results and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                screen.note_command(item);
            if (done)
                screen.check_result(result);
            if (cfg_valid && cfg_ready)
                screen.attribute = cfg_data;
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic tcse_item_t make_item(tcse_cmd_t cmd, logic [CHAR_W-1:0] ch,
                                             logic [IDX_W-1:0] idx);
        tcse_item_t it;
        it.command    = cmd;
        it.char_code  = ch;
        it.cell_index = idx;
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic tcse_item_t random_item();
        tcse_item_t it;
        int         pick;
        int         sel;
        it.char_code  = CHAR_W'($urandom_range(0, 255));
        it.cell_index = IDX_W'($urandom_range(0, 2047));
        pick = $urandom_range(0, 999);
        if (pick < 8)
            it.command = CMD_CLEAR;
        else if (pick < 25)
            it.command = CMD_NONE;
        else if (pick < 180)
        begin
            it.command = CMD_READ;
            // Bias reads towards the cursor row and the bottom row
            sel = $urandom_range(0, 2);
            if (sel == 1)
                it.cell_index = IDX_W'(screen.cursor_row * COLS
                                       + $urandom_range(0, COLS - 1));
            else if (sel == 2)
                it.cell_index = IDX_W'((ROWS - 1) * COLS + $urandom_range(0, COLS - 1));
        end
        else
        begin
            it.command = CMD_PUT;
            sel = $urandom_range(0, 99);
            if (sel < 6)
                it.char_code = CH_NL;
            else if (sel < 12)
                it.char_code = CH_BS;
            else if (sel < 17)
                it.char_code = CH_TAB;
        end
        return it;
    endfunction

    // Hold the command until the engine takes it, then idle for gap cycles
    task automatic send_item(tcse_item_t it, int gap);
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_run(logic [CHAR_W-1:0] ch, int count);
        for (int i = 0; i < count; i++)
            send_item(make_item(CMD_PUT, ch, IDX_W'($urandom_range(0, 2047))), pick_gap());
    endtask

    task automatic write_attribute(logic [ATTR_W-1:0] value);
        start <= 1'b0;
        // let the tracker note the last accepted transaction first
        @(posedge clk);
        while (screen.pending_results.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int               count;
        logic [ATTR_W-1:0] attr_value;

        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        quiet_cycles = 0;
        steady       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset contents, read bounds, backspace at column 0, odd bytes, no-op
        send_item(make_item(CMD_READ, 8'h00, 11'd0), pick_gap());
        send_item(make_item(CMD_READ, 8'hFF, IDX_W'(NCELLS - 1)), pick_gap());
        send_item(make_item(CMD_READ, 8'h00, IDX_W'(NCELLS)), pick_gap());
        send_item(make_item(CMD_READ, 8'hFF, 11'h7FF), pick_gap());
        send_item(make_item(CMD_PUT, CH_BS, 11'h7FF), pick_gap());
        send_item(make_item(CMD_PUT, 8'hFF, 11'd0), pick_gap());
        send_item(make_item(CMD_PUT, 8'h00, 11'd0), pick_gap());
        send_item(make_item(CMD_PUT, 8'h80, 11'd0), pick_gap());
        send_item(make_item(CMD_PUT, CH_TAB, 11'd0), pick_gap());
        send_item(make_item(CMD_PUT, CH_BS, 11'd0), pick_gap());
        send_item(make_item(CMD_READ, 8'h00, 11'd0), pick_gap());
        send_item(make_item(CMD_READ, 8'h00, 11'd1), pick_gap());
        send_item(make_item(CMD_READ, 8'h00, 11'd2), pick_gap());
        send_item(make_item(CMD_READ, 8'h00, 11'd3), pick_gap());
        send_item(make_item(CMD_NONE, 8'hFF, 11'h7FF), pick_gap());
        send_item(make_item(CMD_PUT, CH_NL, 11'd0), pick_gap());
        send_item(make_item(CMD_PUT, 8'h7F, 11'd0), pick_gap());
        send_item(make_item(CMD_READ, 8'h00, IDX_W'(COLS)), pick_gap());
        send_item(make_item(CMD_CLEAR, 8'hFF, 11'h7FF), pick_gap());
        send_item(make_item(CMD_READ, 8'h00, IDX_W'(COLS)), pick_gap());

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                attr_value = 8'h00;
            else if (phase == 1)
                attr_value = 8'hFF;
            else if (phase == 2)
                attr_value = RESET_ATTR;
            else
                attr_value = ATTR_W'($urandom_range(0, 255));
            write_attribute(attr_value);
            steady = ($urandom_range(0, 3) == 0);

            if (phase == 0)
            begin
                // Reach the last row, scroll on newline, then wrap and scroll by tab
                send_run(CH_NL, 26);
                send_run(CH_TAB, 22);
                send_item(make_item(CMD_READ, 8'h00, IDX_W'((ROWS - 2) * COLS)), pick_gap());
                count = 49;
            end
            else
                count = 0;

            while (count < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) == 0)
                begin
                    int burst;
                    burst = $urandom_range(5, 30);
                    send_run(CH_NL, burst);
                    count += burst;
                end
                else
                begin
                    send_item(random_item(), pick_gap());
                    count++;
                end
            end
        end
        start <= 1'b0;
        @(posedge clk);

        while (screen.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (screen.pending_results.size() != 0)
        begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, screen.pending_results.size());
            screen.mismatches++;
        end

        if (screen.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
src/tcse_pkg.sv
src/tcse_ctrl.sv
src/tcse_datapath.sv
src/text_console_screen_engine.sv
src/tcse_checker.sv
tb/text_console_screen_engine_test.sv
